// ===== hw/rtl/rtc_tz_pkg.sv =====
// Shared types, constants and calendar tables for the time-zone adjust pipeline.
package rtc_tz_pkg;

  localparam logic signed [5:0] OFFSET_RESET  = -6'sd3;
  localparam int                HOURS_PER_DAY = 24;
  localparam int                SECS_PER_DAY  = 24 * 60 * 60;
  localparam int                EPOCH_YEAR    = 1970;
  localparam int                BASE_YEAR     = 2000;
  localparam int                DAYS_PER_YEAR = 365;
  localparam logic [4:0]        LEAP_FEB_DAYS = 5'd29;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [2:0] WDAY_FIRST = 3'd1;
  localparam logic [2:0] WDAY_LAST  = 3'd7;

  // Local date and time as it travels down the pipe
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } local_t;

  // Partial epoch terms after the second stage
  typedef struct packed {
    logic signed [9:0] doy;    // day of year from 0, may be -1
    logic [15:0]       ydays;  // days from 1970 to Jan 1 of the year
    logic [16:0]       hms;    // seconds within the day
  } dsum_t;

  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00);
  endfunction

  // Month length; months outside 1..12 count as 31 days
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days of the year before the first of month m (m already in 1..12)
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/rtc_tz_roll.sv =====
// Stage 1: apply hour offset and roll the date by one day when needed.
module rtc_tz_roll import rtc_tz_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic signed [5:0] utc_offset,
  input  logic [5:0]        rtc_second,
  input  logic [5:0]        rtc_minute,
  input  logic [4:0]        rtc_hour,
  input  logic [2:0]        rtc_weekday,
  input  logic [4:0]        rtc_day,
  input  logic [3:0]        rtc_month,
  input  logic [6:0]        rtc_year,
  output local_t            loc
);

  local_t loc_r, loc_nxt;

  always_comb begin
    logic signed [6:0] hsum;
    logic signed [6:0] hadj;
    logic [11:0]       yr;
    logic [3:0]        pm;
    logic [11:0]       py;
    hsum = $signed({2'b00, rtc_hour}) + $signed({utc_offset[5], utc_offset});
    yr   = 12'(BASE_YEAR) + {5'b0, rtc_year};
    hadj = hsum;
    pm   = rtc_month;
    py   = yr;
    loc_nxt.second  = rtc_second;
    loc_nxt.minute  = rtc_minute;
    loc_nxt.weekday = rtc_weekday;
    loc_nxt.day     = rtc_day;
    loc_nxt.month   = rtc_month;
    loc_nxt.year    = yr;

    if (hsum < 0) begin
      // previous day
      hadj = hsum + 7'(HOURS_PER_DAY);
      loc_nxt.weekday = (rtc_weekday > WDAY_FIRST) ? rtc_weekday - 3'd1 : WDAY_LAST;
      if (rtc_day > 5'd1) begin
        loc_nxt.day = rtc_day - 5'd1;
      end else begin
        if (rtc_month > MONTH_JAN) begin
          pm = rtc_month - 4'd1;
        end else begin
          pm = MONTH_DEC;
          py = yr - 12'd1;
        end
        loc_nxt.month = pm;
        loc_nxt.year  = py;
        loc_nxt.day   = (is_leap(py) && pm == MONTH_FEB) ? LEAP_FEB_DAYS : month_len(pm);
      end
    end else if (hsum >= 7'sd24) begin
      // next day
      hadj = hsum - 7'(HOURS_PER_DAY);
      loc_nxt.weekday = (rtc_weekday < WDAY_LAST) ? rtc_weekday + 3'd1 : WDAY_FIRST;
      if (rtc_day < month_len(rtc_month) ||
          (is_leap(yr) && rtc_month == MONTH_FEB && rtc_day < LEAP_FEB_DAYS)) begin
        loc_nxt.day = rtc_day + 5'd1;
      end else begin
        loc_nxt.day = 5'd1;
        if (rtc_month < MONTH_DEC) begin
          loc_nxt.month = rtc_month + 4'd1;
        end else begin
          loc_nxt.month = MONTH_JAN;
          loc_nxt.year  = yr + 12'd1;
        end
      end
    end

    // one correction only; clamp what is still outside the day
    if (hadj < 0) begin
      loc_nxt.hour = 5'd0;
    end else if (hadj > 7'sd23) begin
      loc_nxt.hour = 5'd23;
    end else begin
      loc_nxt.hour = hadj[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc_r <= loc_nxt;
    end
  end

  assign loc = loc_r;

endmodule

// ===== hw/rtl/rtc_tz_days.sv =====
// Stage 2: day of year, whole-year days and seconds within the day.
module rtc_tz_days import rtc_tz_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  local_t loc_in,
  output local_t loc_out,
  output dsum_t  dsum
);

  local_t loc_r;
  dsum_t  dsum_r, dsum_nxt;

  always_comb begin
    logic [3:0]        mi;
    logic signed [9:0] leap_adj;
    logic [7:0]        yo;
    logic [8:0]        leaps;
    mi = (loc_in.month < MONTH_JAN) ? MONTH_JAN :
         ((loc_in.month > MONTH_DEC) ? MONTH_DEC : loc_in.month);
    leap_adj = (is_leap(loc_in.year) && loc_in.month > MONTH_FEB) ? 10'sd1 : 10'sd0;
    dsum_nxt.doy = $signed({5'b0, loc_in.day}) + $signed({1'b0, days_before(mi)})
                   + leap_adj - 10'sd1;

    // years since 1970; leap days of 1970..year-1 reduce to (yo+1)/4
    yo    = 8'(loc_in.year - 12'(EPOCH_YEAR));
    leaps = ({1'b0, yo} + 9'd1) >> 2;
    dsum_nxt.ydays = ({8'b0, yo} * 16'(DAYS_PER_YEAR)) + {7'b0, leaps};

    dsum_nxt.hms = ({12'b0, loc_in.hour} * 17'd3600) + ({11'b0, loc_in.minute} * 17'd60)
                   + {11'b0, loc_in.second};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc_r  <= loc_in;
      dsum_r <= dsum_nxt;
    end
  end

  assign loc_out = loc_r;
  assign dsum    = dsum_r;

endmodule

// ===== hw/rtl/rtc_tz_epoch.sv =====
// Stages 3 and 4: total day count, then scale to seconds and add time of day.
module rtc_tz_epoch import rtc_tz_pkg::*; (
  input  logic        clk,
  input  logic        en3,
  input  logic        en4,
  input  local_t      loc_in,
  input  dsum_t       dsum,
  output local_t      loc_out,
  output logic [31:0] epoch
);

  local_t      loc3_r, loc4_r;
  logic [15:0] days_r, days_nxt;
  logic [16:0] hms_r;
  logic [31:0] epoch_r, epoch_nxt;
  logic [33:0] epoch_sum;

  // day of year can be -1; the total is never negative
  assign days_nxt  = dsum.ydays + 16'($signed(dsum.doy));
  assign epoch_sum = ({18'b0, days_r} * 34'(SECS_PER_DAY)) + {17'b0, hms_r};

  // sums past 32 bits saturate
  assign epoch_nxt = (epoch_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : epoch_sum[31:0];

  always_ff @(posedge clk) begin
    if (en3) begin
      loc3_r <= loc_in;
      days_r <= days_nxt;
      hms_r  <= dsum.hms;
    end
    if (en4) begin
      loc4_r  <= loc3_r;
      epoch_r <= epoch_nxt;
    end
  end

  assign loc_out = loc4_r;
  assign epoch   = epoch_r;

endmodule

// ===== hw/rtl/rtc_timezone_adjust_and_epoch.sv =====
// Top level: four-stage time-zone adjust and Unix epoch pipeline.
//
//  channel | ports                      | direction | handshake
//  --------+----------------------------+-----------+------------------------
//  in      | in_rtc_* (clock reading)   | input     | in_valid / in_ready
//  out     | out_local_*, epoch_seconds | output    | out_valid / out_ready
//  cfg     | cfg_wr_data (utc_offset)   | input     | cfg_wr_en, no wait
//
//  One word enters per cycle unless a stall on out_ready has filled the pipe.
//  The four register stages are roll, day terms, day sum and scale.
//  Each stage takes a new word when it is empty or the stage after it moves,
//  so a stall on out_ready fills bubbles first and loses nothing.
//  rst_n (synchronous) empties the pipe and sets utc_offset to -3.
module rtc_timezone_adjust_and_epoch import rtc_tz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_rtc_second,
  input  logic [5:0]  in_rtc_minute,
  input  logic [4:0]  in_rtc_hour,
  input  logic [2:0]  in_rtc_weekday,
  input  logic [4:0]  in_rtc_day,
  input  logic [3:0]  in_rtc_month,
  input  logic [6:0]  in_rtc_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_local_second,
  output logic [5:0]  out_local_minute,
  output logic [4:0]  out_local_hour,
  output logic [2:0]  out_local_weekday,
  output logic [4:0]  out_local_day,
  output logic [3:0]  out_local_month,
  output logic [11:0] out_local_year,
  output logic [31:0] out_epoch_seconds
);

  logic signed [5:0] utc_offset_r;
  logic [3:0]        vld_r, vld_nxt;
  logic [3:0]        ld;
  local_t            loc1, loc2, loc4;
  dsum_t             dsum2;

  // offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utc_offset_r <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      utc_offset_r <= cfg_wr_data;
    end
  end

  // stage loads: a stage moves when empty or when the next one moves
  assign ld[3] = out_ready | ~vld_r[3];
  assign ld[2] = ld[3] | ~vld_r[2];
  assign ld[1] = ld[2] | ~vld_r[1];
  assign ld[0] = ld[1] | ~vld_r[0];

  always_comb begin
    vld_nxt = vld_r;
    if (ld[0]) vld_nxt[0] = in_valid;
    if (ld[1]) vld_nxt[1] = vld_r[0];
    if (ld[2]) vld_nxt[2] = vld_r[1];
    if (ld[3]) vld_nxt[3] = vld_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 4'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  rtc_tz_roll u_roll (
    .clk         (clk),
    .en          (ld[0]),
    .utc_offset  (utc_offset_r),
    .rtc_second  (in_rtc_second),
    .rtc_minute  (in_rtc_minute),
    .rtc_hour    (in_rtc_hour),
    .rtc_weekday (in_rtc_weekday),
    .rtc_day     (in_rtc_day),
    .rtc_month   (in_rtc_month),
    .rtc_year    (in_rtc_year),
    .loc         (loc1)
  );

  rtc_tz_days u_days (
    .clk     (clk),
    .en      (ld[1]),
    .loc_in  (loc1),
    .loc_out (loc2),
    .dsum    (dsum2)
  );

  rtc_tz_epoch u_epoch (
    .clk     (clk),
    .en3     (ld[2]),
    .en4     (ld[3]),
    .loc_in  (loc2),
    .dsum    (dsum2),
    .loc_out (loc4),
    .epoch   (out_epoch_seconds)
  );

  assign in_ready          = ld[0];
  assign out_valid         = vld_r[3];
  assign out_local_second  = loc4.second;
  assign out_local_minute  = loc4.minute;
  assign out_local_hour    = loc4.hour;
  assign out_local_weekday = loc4.weekday;
  assign out_local_day     = loc4.day;
  assign out_local_month   = loc4.month;
  assign out_local_year    = loc4.year;

endmodule

// ===== hw/rtl/rtc_tz_chk.sv =====
// Port-level checker for the time-zone adjust pipeline, with its bind.
module rtc_tz_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_local_hour,
  input logic [11:0] out_local_year,
  input logic [31:0] out_epoch_seconds
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_epoch_seconds))
    else $error("result word changed while stalled");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // hour is always wrapped or clamped into the day
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_local_hour <= 5'd23)
    else $error("local hour outside 0..23");

  // year moves at most one from the 2000..2127 reading
  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_local_year >= 12'd1999) && (out_local_year <= 12'd2128))
    else $error("local year outside 1999..2128");

endmodule

bind rtc_timezone_adjust_and_epoch rtc_tz_chk u_rtc_tz_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_local_hour    (out_local_hour),
  .out_local_year    (out_local_year),
  .out_epoch_seconds (out_epoch_seconds)
);

// ===== bench/tb_top.sv =====
// Testbench for the time-zone adjust and epoch pipeline: scoreboard, stimulus, checks.
module tb_top;
  import rtc_tz_pkg::*;

  // One clock reading as it goes into the block
  typedef struct {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } reading_t;

  // Local date and time plus the epoch count, one per result word
  typedef struct {
    local_t      loc;
    logic [31:0] epoch;
  } local_epoch_t;

  // Scoreboard: predicts the local time and epoch count of each accepted word and checks results in order
  class tz_scoreboard;
    logic signed [5:0] offset;
    local_epoch_t      due_q[$];
    int                errors;
    int                days_before_month [13] =
      '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function new();
      offset = OFFSET_RESET;
      errors = 0;
    endfunction

    // Length without the leap day; odd month codes count as 31
    static function int base_month_days(int m);
      case (m)
        2:             return 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    static function bit leap_year(int y);
      return (y % 4) == 0;
    endfunction

    function void set_offset(logic [5:0] v);
      offset = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function local_epoch_t local_from_reading(reading_t r);
      int           h, wd, dy, mo, yr, mc;
      longint       days, secs;
      local_epoch_t e;
      h  = int'(r.hour) + int'(offset);
      wd = r.weekday;
      dy = r.day;
      mo = r.month;
      yr = BASE_YEAR + r.year;
      // one day back: weekday, day, month and year roll down
      if (h < 0) begin
        h += HOURS_PER_DAY;
        wd = (wd > 1) ? wd - 1 : 7;
        if (dy > 1) begin
          dy--;
        end else begin
          if (mo > 1) begin
            mo--;
          end else begin
            yr--;
            mo = 12;
          end
          dy = base_month_days(mo);
          if (leap_year(yr) && mo == 2) dy = 29;
        end
      // one day forward
      end else if (h >= HOURS_PER_DAY) begin
        h -= HOURS_PER_DAY;
        wd = (wd < 7) ? wd + 1 : 1;
        if (dy < base_month_days(mo) || (leap_year(yr) && mo == 2 && dy < 29)) begin
          dy++;
        end else begin
          dy = 1;
          if (mo < 12) begin
            mo++;
          end else begin
            mo = 1;
            yr++;
          end
        end
      end
      // a single correction may not be enough; pin the hour to the day
      if (h < 0) h = 0;
      if (h > 23) h = 23;

      // epoch: month index clamped for the table, leap days of earlier years added
      mc   = (mo < 1) ? 1 : ((mo > 12) ? 12 : mo);
      days = dy - 1 + days_before_month[mc];
      if (leap_year(yr) && mo > 2) days += 1;
      days += (yr - 1) / 4 - (EPOCH_YEAR - 1) / 4;
      days += longint'(yr - EPOCH_YEAR) * DAYS_PER_YEAR;
      secs = days * SECS_PER_DAY + h * 3600 + r.minute * 60 + r.second;
      if (secs < 0) secs = 0;
      if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;

      e.loc.second  = r.second;
      e.loc.minute  = r.minute;
      e.loc.hour    = 5'(h);
      e.loc.weekday = 3'(wd);
      e.loc.day     = 5'(dy);
      e.loc.month   = 4'(mo);
      e.loc.year    = 12'(yr);
      e.epoch       = 32'(secs);
      return e;
    endfunction

    function void note_reading(reading_t r);
      due_q.push_back(local_from_reading(r));
    endfunction

    function void cmp_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_local(local_epoch_t got);
      local_epoch_t want;
      if (due_q.size() == 0) begin
        $error("result word with no pending expectation");
        errors++;
        return;
      end
      want = due_q.pop_front();
      cmp_field("local_second", want.loc.second, got.loc.second);
      cmp_field("local_minute", want.loc.minute, got.loc.minute);
      cmp_field("local_hour", want.loc.hour, got.loc.hour);
      cmp_field("local_weekday", want.loc.weekday, got.loc.weekday);
      cmp_field("local_day", want.loc.day, got.loc.day);
      cmp_field("local_month", want.loc.month, got.loc.month);
      cmp_field("local_year", want.loc.year, got.loc.year);
      cmp_field("epoch_seconds", want.epoch, got.epoch);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [5:0]  in_rtc_second;
  logic [5:0]  in_rtc_minute;
  logic [4:0]  in_rtc_hour;
  logic [2:0]  in_rtc_weekday;
  logic [4:0]  in_rtc_day;
  logic [3:0]  in_rtc_month;
  logic [6:0]  in_rtc_year;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [5:0]  out_local_second;
  logic [5:0]  out_local_minute;
  logic [4:0]  out_local_hour;
  logic [2:0]  out_local_weekday;
  logic [4:0]  out_local_day;
  logic [3:0]  out_local_month;
  logic [11:0] out_local_year;
  logic [31:0] out_epoch_seconds;

  tz_scoreboard sb;
  bit           rx_steady = 1'b0;
  bit           tx_steady = 1'b0;
  int           stall_left = 0;

  always #6 clk = ~clk;

  rtc_timezone_adjust_and_epoch i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rtc_second     (in_rtc_second),
    .in_rtc_minute     (in_rtc_minute),
    .in_rtc_hour       (in_rtc_hour),
    .in_rtc_weekday    (in_rtc_weekday),
    .in_rtc_day        (in_rtc_day),
    .in_rtc_month      (in_rtc_month),
    .in_rtc_year       (in_rtc_year),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_local_second  (out_local_second),
    .out_local_minute  (out_local_minute),
    .out_local_hour    (out_local_hour),
    .out_local_weekday (out_local_weekday),
    .out_local_day     (out_local_day),
    .out_local_month   (out_local_month),
    .out_local_year    (out_local_year),
    .out_epoch_seconds (out_epoch_seconds)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(2, 1);
    if (r < 92) return $urandom_range(6, 3);
    return $urandom_range(40, 12);
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rx_steady) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < 20) begin
      out_ready <= 1'b0;
      stall_left <= stall_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: note accepted words and register writes, check result words
  always @(posedge clk) begin
    reading_t     rd;
    local_epoch_t got;
    if (rst_n) begin
      if (cfg_wr_en) sb.set_offset(cfg_wr_data);
      if (in_valid && in_ready) begin
        rd.second  = in_rtc_second;
        rd.minute  = in_rtc_minute;
        rd.hour    = in_rtc_hour;
        rd.weekday = in_rtc_weekday;
        rd.day     = in_rtc_day;
        rd.month   = in_rtc_month;
        rd.year    = in_rtc_year;
        sb.note_reading(rd);
      end
      if (out_valid && out_ready) begin
        got.loc.second  = out_local_second;
        got.loc.minute  = out_local_minute;
        got.loc.hour    = out_local_hour;
        got.loc.weekday = out_local_weekday;
        got.loc.day     = out_local_day;
        got.loc.month   = out_local_month;
        got.loc.year    = out_local_year;
        got.epoch       = out_epoch_seconds;
        sb.check_local(got);
      end
    end
  end

  function automatic reading_t mk(int s, int mi, int h, int wd, int d, int mo, int y);
    reading_t r;
    r.second  = 6'(s);
    r.minute  = 6'(mi);
    r.hour    = 5'(h);
    r.weekday = 3'(wd);
    r.day     = 5'(d);
    r.month   = 4'(mo);
    r.year    = 7'(y);
    return r;
  endfunction

  // Mostly valid dates near day, month and year boundaries; some raw bit patterns
  function automatic reading_t random_reading();
    reading_t r;
    int       len;
    if ($urandom_range(99) < 15) begin
      r.second  = 6'($urandom);
      r.minute  = 6'($urandom);
      r.hour    = 5'($urandom);
      r.weekday = 3'($urandom);
      r.day     = 5'($urandom);
      r.month   = 4'($urandom);
      r.year    = 7'($urandom);
      return r;
    end
    r.second  = ($urandom_range(9) == 0) ? 6'd59 : 6'($urandom_range(59));
    r.minute  = ($urandom_range(9) == 0) ? 6'd59 : 6'($urandom_range(59));
    r.year    = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 7'd99 : 7'd0)
                                         : 7'($urandom_range(99));
    r.month   = 4'($urandom_range(12, 1));
    r.weekday = 3'($urandom_range(7, 1));
    len = tz_scoreboard::base_month_days(r.month);
    if (r.month == MONTH_FEB && tz_scoreboard::leap_year(BASE_YEAR + r.year)) len = 29;
    case ($urandom_range(4))
      0:       r.day = 5'd1;
      1:       r.day = 5'(len);
      2:       r.day = 5'(len - 1);
      default: r.day = 5'($urandom_range(len, 1));
    endcase
    if ($urandom_range(2) == 0) begin
      r.hour = $urandom_range(1) ? 5'($urandom_range(3)) : 5'(23 - $urandom_range(3));
    end else begin
      r.hour = 5'($urandom_range(23));
    end
    return r;
  endfunction

  task automatic send_reading(reading_t r);
    in_valid       <= 1'b1;
    in_rtc_second  <= r.second;
    in_rtc_minute  <= r.minute;
    in_rtc_hour    <= r.hour;
    in_rtc_weekday <= r.weekday;
    in_rtc_day     <= r.day;
    in_rtc_month   <= r.month;
    in_rtc_year    <= r.year;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold the sender until every pending result word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(logic signed [5:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    rx_steady   <= ($urandom_range(3) == 0);
    tx_steady   <= ($urandom_range(3) == 0);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_spaced(reading_t r);
    int g;
    send_reading(r);
    g = tx_steady ? 0 : gap_len();
    if (g > 0) pause(g);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      send_spaced(random_reading());
      if ($urandom_range(99) < 2) wait_drained();
    end
  endtask

  // Default offset of -3: backward rollovers and odd field codes
  task automatic run_directed_back();
    send_spaced(mk(0, 0, 0, 1, 1, 1, 0));       // new year back into 1999
    send_spaced(mk(59, 59, 23, 7, 31, 12, 99)); // largest normal reading, no roll
    send_spaced(mk(30, 15, 2, 4, 1, 3, 4));     // Mar 1 leap year back to Feb 29
    send_spaced(mk(30, 15, 1, 4, 1, 3, 5));     // Mar 1 plain year back to Feb 28
    send_spaced(mk(0, 0, 0, 0, 15, 6, 10));     // weekday zero going back
    send_spaced(mk(0, 0, 5, 0, 10, 6, 10));     // weekday zero, no roll
    send_spaced(mk(1, 2, 0, 3, 0, 5, 20));      // day zero going back
    send_spaced(mk(0, 0, 1, 2, 1, 0, 8));       // month zero going back
    send_spaced(mk(0, 0, 2, 2, 0, 0, 8));       // month and day zero going back
    send_spaced(mk(5, 5, 10, 5, 10, 0, 8));     // month zero, no roll
    send_spaced(mk(5, 5, 10, 5, 10, 15, 8));    // month fifteen, no roll
    send_spaced(mk(0, 0, 0, 6, 1, 13, 30));     // month thirteen going back
    send_spaced(mk(63, 63, 31, 7, 31, 15, 127)); // all ones, epoch saturates
    send_spaced(mk(0, 0, 0, 0, 0, 0, 0));       // all zeros
    send_spaced(mk(0, 0, 26, 1, 28, 2, 3));     // hour above 23 pulled back in range
  endtask

  // Offset of +23: forward rollovers
  task automatic run_directed_fwd();
    send_spaced(mk(59, 59, 23, 7, 31, 12, 99)); // into 2100, weekday wraps to 1
    send_spaced(mk(0, 0, 1, 3, 28, 2, 4));      // Feb 28 leap year to Feb 29
    send_spaced(mk(0, 0, 1, 3, 29, 2, 4));      // Feb 29 to Mar 1
    send_spaced(mk(0, 0, 1, 3, 28, 2, 5));      // Feb 28 plain year to Mar 1
    send_spaced(mk(0, 0, 5, 0, 30, 4, 5));      // month end, weekday zero forward
    send_spaced(mk(0, 0, 31, 2, 31, 1, 50));    // hour still too large, pinned to 23
    send_spaced(mk(0, 0, 0, 2, 10, 5, 50));     // hour 23, no roll
    send_spaced(mk(0, 0, 3, 4, 31, 13, 127));   // month thirteen forward, epoch saturates
    send_spaced(mk(0, 0, 3, 4, 30, 4, 20));     // last day of a 30-day month
  endtask

  initial begin
    int offsets [10] = '{0, -23, -32, 31, 1, -1, 12, -12, 7, -7};
    sb = new();
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_rtc_second  <= '0;
    in_rtc_minute  <= '0;
    in_rtc_hour    <= '0;
    in_rtc_weekday <= '0;
    in_rtc_day     <= '0;
    in_rtc_month   <= '0;
    in_rtc_year    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed_back();
    run_random(125);
    write_offset(6'sd23);
    run_directed_fwd();
    run_random(125);
    foreach (offsets[k]) begin
      write_offset(6'(offsets[k]));
      run_random(110);
    end
    write_offset(6'($urandom_range(63)));
    run_random(150);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(12 * 800000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
